// ===== sv/dihed_pkg.sv =====
// Shared constants, types and helpers for the dihedral angle pipeline.
`timescale 1ns / 1ps
package dihed_pkg;

    localparam int CoordW  = 32;
    localparam int DiffW   = 34;
    localparam int AngleW  = 25;
    localparam int CordicSteps = 24;
    localparam int CordW   = 34;   // CORDIC x/y width, covers growth past 2^30
    localparam int ZW      = 34;   // Q.24 degree accumulator

    localparam logic signed [ZW-1:0] Deg180Q24 = 34'sd3019898880;
    localparam logic signed [ZW-1:0] Deg90Q24  = 34'sd1509949440;
    localparam logic signed [AngleW-1:0] AngleMaxQ16 = 25'sd11796480;

    typedef logic signed [DiffW-1:0] diff_t;
    typedef logic signed [30:0]      v30_t;   // |v| < 2^30
    typedef logic signed [19:0]      v19_t;   // |v| < 2^19
    typedef logic signed [CordW-1:0] cord_t;
    typedef logic signed [ZW-1:0]    ang_t;

    typedef struct packed {
        v30_t x;
        v30_t y;
        v30_t z;
    } vec30_t;

    typedef struct packed {
        v19_t x;
        v19_t y;
        v19_t z;
    } vec19_t;

    function automatic ang_t atan_q24(input int i);
        ang_t t;
        unique case (i)
            0: t = 34'sd754974720;   1: t = 34'sd445687602;
            2: t = 34'sd235489088;   3: t = 34'sd119537938;
            4: t = 34'sd60000934;    5: t = 34'sd30029717;
            6: t = 34'sd15018523;    7: t = 34'sd7509720;
            8: t = 34'sd3754917;     9: t = 34'sd1877466;
            10: t = 34'sd938734;     11: t = 34'sd469367;
            12: t = 34'sd234684;     13: t = 34'sd117342;
            14: t = 34'sd58671;      15: t = 34'sd29335;
            16: t = 34'sd14668;      17: t = 34'sd7334;
            18: t = 34'sd3667;       19: t = 34'sd1833;
            20: t = 34'sd917;        21: t = 34'sd458;
            22: t = 34'sd229;        default: t = 34'sd115;
        endcase
        return t;
    endfunction

    // Magnitude of a signed 64-bit value (most negative maps to 2^63).
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Least right shift bringing m below 2^bits.
    function automatic logic [6:0] shift_for(input logic [63:0] m, input int bits);
        logic [6:0] s;
        s = 7'd0;
        for (int k = 63; k >= 0; k--) begin
            if (k >= bits && m[k] && s == 7'd0) s = 7'(k - bits + 1);
        end
        return s;
    endfunction

    // Shift toward zero.
    function automatic logic signed [63:0] shift_tz(input logic signed [63:0] v,
                                                    input logic [6:0] s);
        logic [63:0] m;
        m = mag64(v) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== sv/dihedral_angle_four_points_top.sv =====
// Dihedral angle pipeline: four points in, torsion angle in degrees out.
// One beat is accepted every clock while tready is high; its result passes
// through six stages of vector arithmetic, an input register and a 20-stage square root
// (one root bit per stage), one stage for X = r * (p.q), one for the quadrant
// fold and pre-scale, the 24-step CORDIC unrolled into one stage per step,
// then the output register. The whole pipe advances together under one
// enable, so a stalled output holds every stage and nothing is lost or
// repeated; tready falls only when the output register is full and not
// being taken.
`timescale 1ns / 1ps
module dihedral_angle_four_points_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, second_x..z, third_x..z, fourth_x..z, 32 b each
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // angle_deg[24:0]; zero pad to 32
    output logic [31:0]  m_tdata,
    // degenerate
    output logic         m_tuser
);
    localparam int SqStages = 20;
    localparam int CordicStagesC = dihed_pkg::CordicSteps;
    localparam int NStg = 6 + SqStages + 1 + CordicStagesC + 2;

    logic adv;
    logic [NStg-1:0] vld_reg;
    logic out_vld_reg;
    logic [dihed_pkg::AngleW-1:0] out_ang_reg;
    logic out_deg_reg;

    assign adv = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: differences
    dihed_pkg::diff_t b1_reg [3], u_reg [3], b3_reg [3];
    logic signed [dihed_pkg::CoordW-1:0] pt [12];
    always_comb begin
        for (int i = 0; i < 12; i++) pt[i] = s_tdata[32*i +: 32];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                b1_reg[i] <= 34'(pt[i]) - 34'(pt[3+i]);
                u_reg[i]  <= 34'(pt[6+i]) - 34'(pt[3+i]);
                b3_reg[i] <= 34'(pt[9+i]) - 34'(pt[6+i]);
            end
        end
    end

    // ---------------- stage 2: scale to 30 bits
    dihed_pkg::vec30_t b1s_reg, us_reg, b3s_reg;
    logic deg2_reg;
    function automatic dihed_pkg::vec30_t sc30(input dihed_pkg::diff_t v [3]);
        logic [63:0] m;
        logic [6:0] s;
        dihed_pkg::vec30_t r;
        m = 64'd0;
        for (int i = 0; i < 3; i++)
            if (dihed_pkg::mag64(64'(v[i])) > m) m = dihed_pkg::mag64(64'(v[i]));
        s = dihed_pkg::shift_for(m, 30);
        r.x = 31'(dihed_pkg::shift_tz(64'(v[0]), s));
        r.y = 31'(dihed_pkg::shift_tz(64'(v[1]), s));
        r.z = 31'(dihed_pkg::shift_tz(64'(v[2]), s));
        return r;
    endfunction
    always_ff @(posedge aclk) begin
        if (adv) begin
            b1s_reg <= sc30(b1_reg);
            us_reg  <= sc30(u_reg);
            b3s_reg <= sc30(b3_reg);
            deg2_reg <= (u_reg[0] == '0) && (u_reg[1] == '0) && (u_reg[2] == '0);
        end
    end

    // ---------------- stage 3: products for cross terms
    logic signed [61:0] pm_reg [12];
    dihed_pkg::vec30_t u3_reg;
    logic deg3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            pm_reg[0]  <= b1s_reg.y * us_reg.z;  pm_reg[1]  <= b1s_reg.z * us_reg.y;
            pm_reg[2]  <= b1s_reg.z * us_reg.x;  pm_reg[3]  <= b1s_reg.x * us_reg.z;
            pm_reg[4]  <= b1s_reg.x * us_reg.y;  pm_reg[5]  <= b1s_reg.y * us_reg.x;
            pm_reg[6]  <= b3s_reg.y * us_reg.z;  pm_reg[7]  <= b3s_reg.z * us_reg.y;
            pm_reg[8]  <= b3s_reg.z * us_reg.x;  pm_reg[9]  <= b3s_reg.x * us_reg.z;
            pm_reg[10] <= b3s_reg.x * us_reg.y;  pm_reg[11] <= b3s_reg.y * us_reg.x;
            u3_reg <= us_reg;
            deg3_reg <= deg2_reg;
        end
    end

    // ---------------- stage 4: cross products and scale to 19 bits
    dihed_pkg::vec19_t p_reg, q_reg, u4_reg;
    logic deg4_reg;
    function automatic dihed_pkg::vec19_t sc19(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               input logic signed [63:0] c);
        logic [63:0] m;
        logic [6:0] s;
        dihed_pkg::vec19_t r;
        m = dihed_pkg::mag64(a);
        if (dihed_pkg::mag64(b) > m) m = dihed_pkg::mag64(b);
        if (dihed_pkg::mag64(c) > m) m = dihed_pkg::mag64(c);
        s = dihed_pkg::shift_for(m, 19);
        r.x = 20'(dihed_pkg::shift_tz(a, s));
        r.y = 20'(dihed_pkg::shift_tz(b, s));
        r.z = 20'(dihed_pkg::shift_tz(c, s));
        return r;
    endfunction
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg <= sc19(64'(pm_reg[0]) - 64'(pm_reg[1]), 64'(pm_reg[2]) - 64'(pm_reg[3]),
                          64'(pm_reg[4]) - 64'(pm_reg[5]));
            q_reg <= sc19(64'(pm_reg[6]) - 64'(pm_reg[7]), 64'(pm_reg[8]) - 64'(pm_reg[9]),
                          64'(pm_reg[10]) - 64'(pm_reg[11]));
            u4_reg <= sc19(64'(u3_reg.x), 64'(u3_reg.y), 64'(u3_reg.z));
            deg4_reg <= deg3_reg;
        end
    end

    // ---------------- stage 5: products for dots and p x q
    logic signed [39:0] d_reg [9];
    logic signed [39:0] c_reg [6];
    dihed_pkg::vec19_t u5_reg;
    logic deg5_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[0] <= u4_reg.x * u4_reg.x; d_reg[1] <= u4_reg.y * u4_reg.y;
            d_reg[2] <= u4_reg.z * u4_reg.z;
            d_reg[3] <= p_reg.x * q_reg.x;   d_reg[4] <= p_reg.y * q_reg.y;
            d_reg[5] <= p_reg.z * q_reg.z;
            d_reg[6] <= '0; d_reg[7] <= '0; d_reg[8] <= '0;
            c_reg[0] <= p_reg.y * q_reg.z;   c_reg[1] <= p_reg.z * q_reg.y;
            c_reg[2] <= p_reg.z * q_reg.x;   c_reg[3] <= p_reg.x * q_reg.z;
            c_reg[4] <= p_reg.x * q_reg.y;   c_reg[5] <= p_reg.y * q_reg.x;
            u5_reg <= u4_reg;
            deg5_reg <= deg4_reg;
        end
    end

    // ---------------- stage 6: sums, then u.(p x q) products
    logic [41:0] uu_reg;
    logic signed [41:0] pq_reg;
    logic signed [62:0] y_prod_reg [3];
    logic deg6_reg;
    logic signed [41:0] cx, cy, cz;
    always_comb begin
        cx = 42'(d_reg[8]) + 42'(c_reg[0]) - 42'(c_reg[1]);
        cy = 42'(c_reg[2]) - 42'(c_reg[3]);
        cz = 42'(c_reg[4]) - 42'(c_reg[5]);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            uu_reg <= 42'(d_reg[0]) + 42'(d_reg[1]) + 42'(d_reg[2]) + 42'(d_reg[6]);
            pq_reg <= 42'(d_reg[3]) + 42'(d_reg[4]) + 42'(d_reg[5]) + 42'(d_reg[7]);
            y_prod_reg[0] <= 63'(u5_reg.x) * 63'(cx);
            y_prod_reg[1] <= 63'(u5_reg.y) * 63'(cy);
            y_prod_reg[2] <= 63'(u5_reg.z) * 63'(cz);
            deg6_reg <= deg5_reg;
        end
    end

    // ---------------- square root, one result bit per stage
    logic [41:0] sq_rem_reg [SqStages+1];
    logic [21:0] sq_res_reg [SqStages+1];
    logic signed [41:0] sq_pq_reg [SqStages+1];
    logic signed [63:0] sq_y_reg [SqStages+1];
    logic sq_deg_reg [SqStages+1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_rem_reg[0] <= uu_reg;
            sq_res_reg[0] <= '0;
            sq_pq_reg[0]  <= pq_reg;
            sq_y_reg[0]   <= 64'(y_prod_reg[0]) + 64'(y_prod_reg[1]) + 64'(y_prod_reg[2]);
            sq_deg_reg[0] <= deg6_reg;
        end
    end
    // u.u stays below 2^40, so the root has 20 bits
    for (genvar g = 0; g < SqStages; g++) begin : g_sq
        localparam int B = SqStages - 1 - g;  // bit position of the root under test
        logic [43:0] trial;
        logic [21:0] rn;
        logic [41:0] remn;
        always_comb begin
            rn = sq_res_reg[g];
            remn = sq_rem_reg[g];
            trial = (44'(sq_res_reg[g]) << (B + 1)) + (44'd1 << (2 * B));
            if (44'(sq_rem_reg[g]) >= trial) begin
                remn = 42'(44'(sq_rem_reg[g]) - trial);
                rn = sq_res_reg[g] | (22'd1 << B);
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[g+1] <= remn;
                sq_res_reg[g+1] <= rn;
                sq_pq_reg[g+1]  <= sq_pq_reg[g];
                sq_y_reg[g+1]   <= sq_y_reg[g];
                sq_deg_reg[g+1] <= sq_deg_reg[g];
            end
        end
    end

    // ---------------- X = r * (p.q), then quadrant fold and pre-scale
    logic signed [63:0] xv_reg, yv_reg;
    logic degx_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            xv_reg <= 64'($signed({1'b0, sq_res_reg[SqStages]})) * 64'(sq_pq_reg[SqStages]);
            yv_reg <= sq_y_reg[SqStages];
            degx_reg <= sq_deg_reg[SqStages];
        end
    end

    // special cases resolved here and carried alongside the CORDIC
    localparam logic [1:0] ModeCordic = 2'd0;
    localparam logic [1:0] ModeFixed  = 2'd1;
    localparam logic [1:0] ModeZero   = 2'd2;

    dihed_pkg::cord_t cx_reg [CordicStagesC+1], cy_reg [CordicStagesC+1];
    dihed_pkg::ang_t  cz_reg [CordicStagesC+1];
    logic [1:0] cm_reg [CordicStagesC+1];
    logic cdeg_reg [CordicStagesC+1];
    logic signed [63:0] fx, fy;
    dihed_pkg::ang_t fz;
    logic [1:0] fm;
    logic [63:0] fmax;
    logic [6:0] fs;
    always_comb begin
        fx = xv_reg;
        fy = yv_reg;
        fz = '0;
        fm = ModeCordic;
        if (degx_reg || (xv_reg == 0 && yv_reg == 0)) begin
            fm = ModeZero;
        end else if (yv_reg == 0) begin
            fm = ModeFixed;
            fz = xv_reg < 0 ? dihed_pkg::Deg180Q24 : '0;
        end else if (xv_reg == 0) begin
            fm = ModeFixed;
            fz = yv_reg > 0 ? dihed_pkg::Deg90Q24 : -dihed_pkg::Deg90Q24;
        end else if (xv_reg < 0) begin
            fz = yv_reg > 0 ? dihed_pkg::Deg180Q24 : -dihed_pkg::Deg180Q24;
            fx = -xv_reg;
            fy = -yv_reg;
        end
        fmax = dihed_pkg::mag64(fx) > dihed_pkg::mag64(fy) ?
               dihed_pkg::mag64(fx) : dihed_pkg::mag64(fy);
        fs = dihed_pkg::shift_for(fmax, 30);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg[0] <= 34'(dihed_pkg::shift_tz(fx, fs));
            cy_reg[0] <= 34'(dihed_pkg::shift_tz(fy, fs));
            cz_reg[0] <= fz;
            cm_reg[0] <= fm;
            cdeg_reg[0] <= degx_reg;
        end
    end

    // ---------------- CORDIC, one micro-rotation per stage
    for (genvar g = 0; g < CordicStagesC; g++) begin : g_cordic
        dihed_pkg::cord_t dx, dy;
        assign dx = cx_reg[g] >>> g;
        assign dy = cy_reg[g] >>> g;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (cm_reg[g] != ModeCordic) begin
                    // hold the preloaded angle of an axis or zero case
                    cx_reg[g+1] <= cx_reg[g];
                    cy_reg[g+1] <= cy_reg[g];
                    cz_reg[g+1] <= cz_reg[g];
                end else if (!cy_reg[g][dihed_pkg::CordW-1]) begin
                    cx_reg[g+1] <= cx_reg[g] + dy;
                    cy_reg[g+1] <= cy_reg[g] - dx;
                    cz_reg[g+1] <= cz_reg[g] + dihed_pkg::atan_q24(g);
                end else begin
                    cx_reg[g+1] <= cx_reg[g] - dy;
                    cy_reg[g+1] <= cy_reg[g] + dx;
                    cz_reg[g+1] <= cz_reg[g] - dihed_pkg::atan_q24(g);
                end
                cm_reg[g+1] <= cm_reg[g];
                cdeg_reg[g+1] <= cdeg_reg[g];
            end
        end
    end

    // ---------------- round, clamp, output register
    dihed_pkg::ang_t zfin;
    logic signed [dihed_pkg::ZW-9:0] zr;
    logic signed [dihed_pkg::AngleW-1:0] ang_n;
    always_comb begin
        zfin = cz_reg[CordicStagesC];
        zr = 26'((zfin + 34'sd128) >>> 8);
        if (zr > 26'(dihed_pkg::AngleMaxQ16)) ang_n = dihed_pkg::AngleMaxQ16;
        else if (zr < -26'(dihed_pkg::AngleMaxQ16)) ang_n = -dihed_pkg::AngleMaxQ16;
        else ang_n = 25'(zr);
        if (cm_reg[CordicStagesC] == ModeZero) ang_n = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NStg-2:0], s_tvalid};
            out_vld_reg <= vld_reg[NStg-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_ang_reg <= ang_n;
            out_deg_reg <= cdeg_reg[CordicStagesC];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_ang_reg};
    assign m_tuser  = out_deg_reg;
endmodule

// ===== sv/dihed_checker.sv =====
// Port-level checks for the dihedral angle pipeline.
`timescale 1ns / 1ps
module dihed_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("degenerate result with nonzero angle");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:25] == 7'd0)
        else $error("pad bits set");
endmodule

bind dihedral_angle_four_points_top dihed_checker u_dihed_checker (.*);
